>>> design/acs_pkg.sv
// Shared types, codes, constants and field helpers for the alarm clock controller.
`default_nettype none

package acs_pkg;

  // Operation codes of one request
  typedef enum logic [1:0] {
    OP_KEY     = 2'd0,
    OP_REFRESH = 2'd1,
    OP_TICK    = 2'd2
  } op_t;

  // Setting modes
  typedef enum logic [2:0] {
    MODE_IDLE     = 3'd0,
    MODE_CLK_HOUR = 3'd1,
    MODE_CLK_MIN  = 3'd2,
    MODE_CLK_SEC  = 3'd3,
    MODE_ALM_HOUR = 3'd4,
    MODE_ALM_MIN  = 3'd5,
    MODE_ALM_SEC  = 3'd6
  } mode_t;

  // Blanked digit pair codes
  typedef enum logic [1:0] {
    BLANK_NONE   = 2'd0,
    BLANK_HOUR   = 2'd1,
    BLANK_MINUTE = 2'd2,
    BLANK_SECOND = 2'd3
  } blank_t;

  localparam logic [7:0] KEY_NONE  = 8'd0;
  localparam logic [7:0] KEY_ALARM = 8'd4;
  localparam logic [7:0] KEY_CLOCK = 8'd5;
  localparam logic [7:0] KEY_DOWN  = 8'd8;
  localparam logic [7:0] KEY_UP    = 8'd9;

  localparam logic [5:0] HOURS   = 6'd24;
  localparam logic [5:0] MINUTES = 6'd60;

  localparam logic [4:0] RESET_HOUR   = 5'd23;
  localparam logic [5:0] RESET_MINUTE = 6'd59;
  localparam logic [5:0] RESET_SECOND = 6'd50;

  localparam logic [4:0] ALARM_STEPS   = 5'd25;
  localparam int         BLINK_MS      = 200;
  localparam int         MS_PER_SECOND = 1000;
  localparam int         BLINK_SLOTS   = MS_PER_SECOND / BLINK_MS;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] key_value;
    logic [4:0] clock_hour;
    logic [5:0] clock_minute;
    logic [5:0] clock_second;
  } item_t;

  typedef struct packed {
    logic [2:0] mode;
    logic [4:0] shown_hour;
    logic [5:0] shown_minute;
    logic [5:0] shown_second;
    logic [1:0] blanked_pair;
    logic       show_temperature;
    logic       alarm_led;
    logic       write_clock;
  } result_t;

  // Step a field up or down with wrap; out-of-range values go to 0 (up) or span-1 (down)
  function automatic logic [5:0] step_field(logic [5:0] v, logic [5:0] span, logic up);
    logic [5:0] r;
    if (up) begin
      r = (v >= span - 6'd1) ? 6'd0 : v + 6'd1;
    end else begin
      r = (v == 6'd0 || v >= span) ? span - 6'd1 : v - 6'd1;
    end
    return r;
  endfunction

  // True on a millisecond count that lies on a blink boundary
  function automatic logic blink_step(logic [9:0] ms);
    logic hit;
    hit = 1'b0;
    for (int k = 0; k < BLINK_SLOTS; k++) begin
      if (ms == 10'(k * BLINK_MS)) hit = 1'b1;
    end
    return hit;
  endfunction

endpackage

`default_nettype wire

>>> design/acs_if.sv
// Valid/ready channel interfaces for requests and results.
`default_nettype none

interface acs_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] op;
  logic [7:0] key_value;
  logic [4:0] clock_hour;
  logic [5:0] clock_minute;
  logic [5:0] clock_second;

  modport source (output valid, op, key_value, clock_hour, clock_minute, clock_second,
                  input ready);
  modport sink (input valid, op, key_value, clock_hour, clock_minute, clock_second,
                output ready);
endinterface

interface acs_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] mode;
  logic [4:0] shown_hour;
  logic [5:0] shown_minute;
  logic [5:0] shown_second;
  logic [1:0] blanked_pair;
  logic       show_temperature;
  logic       alarm_led;
  logic       write_clock;

  modport source (output valid, mode, shown_hour, shown_minute, shown_second, blanked_pair,
                  show_temperature, alarm_led, write_clock, input ready);
  modport sink (input valid, mode, shown_hour, shown_minute, shown_second, blanked_pair,
                show_temperature, alarm_led, write_clock, output ready);
endinterface

`default_nettype wire

>>> design/alarm_clock_setting_controller_core.sv
// A request passes 2 registers: the input register, then the result register, which it enters once that has room.
// Throughput: one request per cycle while the result register has room; the controller state updates once per request.
// While a result waits in the result register, the input register takes one more request and then holds ready low.
// Reset (rst, synchronous, active high): mode idle, time 23:59:50, alarm 00:00:00,
// alarm, view and tick counters cleared, both channel stages emptied.
`default_nettype none

module alarm_clock_setting_controller_core
  import acs_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  acs_in_if.sink    item,
  acs_out_if.source result
);

  logic    held_valid;
  item_t   held;
  logic    space;
  logic    advance;
  result_t res;

  // move the held request through the controller when the result register has room
  assign advance = held_valid && space;

  acs_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .item       (item),
    .advance    (advance),
    .held_valid (held_valid),
    .held       (held)
  );

  acs_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .fire (advance),
    .held (held),
    .res  (res)
  );

  acs_out_stage u_out (
    .clk    (clk),
    .rst    (rst),
    .load   (advance),
    .res    (res),
    .space  (space),
    .result (result)
  );

endmodule

`default_nettype wire

>>> design/acs_in_stage.sv
// Input register stage: captures one request per cycle while it is empty or its held request moves on.
`default_nettype none

module acs_in_stage
  import acs_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  acs_in_if.sink    item,
  input  wire logic advance,
  output logic      held_valid,
  output item_t     held
);

  assign item.ready = !held_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (item.valid && item.ready) begin
      held_valid <= 1'b1;
    end else if (advance) begin
      held_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item.valid && item.ready) begin
      held.op           <= item.op;
      held.key_value    <= item.key_value;
      held.clock_hour   <= item.clock_hour;
      held.clock_minute <= item.clock_minute;
      held.clock_second <= item.clock_second;
    end
  end

endmodule

`default_nettype wire

>>> design/acs_ctrl.sv
// Controller state and the single-pass update for one request.
`default_nettype none

module acs_ctrl
  import acs_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  fire,
  input  wire item_t held,
  output result_t    res
);

  mode_t      setting_mode, setting_mode_next;
  logic [4:0] time_hour, time_hour_next;
  logic [5:0] time_minute, time_minute_next;
  logic [5:0] time_second, time_second_next;
  logic [4:0] alarm_hour, alarm_hour_next;
  logic [5:0] alarm_minute, alarm_minute_next;
  logic [5:0] alarm_second, alarm_second_next;
  logic [7:0] previous_key, previous_key_next;
  logic       temperature_view, temperature_view_next;
  logic [4:0] blinks_left, blinks_left_next;
  logic       led_level, led_level_next;
  logic [9:0] millisecond_count, millisecond_count_next;
  logic       second_parity, second_parity_next;

  logic [7:0] press;
  logic       up;
  logic [5:0] hour_step;
  logic [5:0] ahour_step;
  logic [9:0] ms_inc;
  logic [4:0] blinks_dec;
  logic       alarm_view;
  blank_t     blank;
  logic       write_clock;

  assign press      = held.key_value & (previous_key ^ held.key_value);
  assign up         = (press == KEY_UP);
  assign hour_step  = step_field({1'b0, time_hour}, HOURS, up);
  assign ahour_step = step_field({1'b0, alarm_hour}, HOURS, up);
  assign ms_inc     = millisecond_count + 10'd1;
  assign blinks_dec = blinks_left - 5'd1;

  always_comb begin
    setting_mode_next      = setting_mode;
    time_hour_next         = time_hour;
    time_minute_next       = time_minute;
    time_second_next       = time_second;
    alarm_hour_next        = alarm_hour;
    alarm_minute_next      = alarm_minute;
    alarm_second_next      = alarm_second;
    previous_key_next      = previous_key;
    temperature_view_next  = temperature_view;
    blinks_left_next       = blinks_left;
    led_level_next         = led_level;
    millisecond_count_next = millisecond_count;
    second_parity_next     = second_parity;
    blank                  = BLANK_NONE;
    write_clock            = 1'b0;

    case (held.op)
      OP_KEY: begin
        previous_key_next = held.key_value;
        if (press == KEY_CLOCK) begin
          case (setting_mode)
            MODE_IDLE:     setting_mode_next = MODE_CLK_HOUR;
            MODE_CLK_HOUR: setting_mode_next = MODE_CLK_MIN;
            MODE_CLK_MIN:  setting_mode_next = MODE_CLK_SEC;
            MODE_CLK_SEC: begin
              setting_mode_next = MODE_IDLE;
              write_clock       = 1'b1;
            end
            default: setting_mode_next = setting_mode;
          endcase
        end else if (press == KEY_ALARM) begin
          case (setting_mode)
            MODE_IDLE:     setting_mode_next = MODE_ALM_HOUR;
            MODE_ALM_HOUR: setting_mode_next = MODE_ALM_MIN;
            MODE_ALM_MIN:  setting_mode_next = MODE_ALM_SEC;
            MODE_ALM_SEC:  setting_mode_next = MODE_IDLE;
            default:       setting_mode_next = setting_mode;
          endcase
        end else if (press == KEY_UP || press == KEY_DOWN) begin
          case (setting_mode)
            MODE_CLK_HOUR: time_hour_next    = hour_step[4:0];
            MODE_CLK_MIN:  time_minute_next  = step_field(time_minute, MINUTES, up);
            MODE_CLK_SEC:  time_second_next  = step_field(time_second, MINUTES, up);
            MODE_ALM_HOUR: alarm_hour_next   = ahour_step[4:0];
            MODE_ALM_MIN:  alarm_minute_next = step_field(alarm_minute, MINUTES, up);
            MODE_ALM_SEC:  alarm_second_next = step_field(alarm_second, MINUTES, up);
            default: ;
          endcase
        end
        // holding the down key in idle selects the temperature view
        if (setting_mode_next == MODE_IDLE && held.key_value == KEY_DOWN) begin
          temperature_view_next = 1'b1;
        end
        if (setting_mode_next == MODE_IDLE && held.key_value == KEY_NONE) begin
          temperature_view_next = 1'b0;
        end
        // any press cancels a running alarm
        if (press != KEY_NONE && blinks_left != 5'd0) begin
          blinks_left_next = 5'd0;
          led_level_next   = 1'b0;
        end
      end

      OP_REFRESH: begin
        if (!temperature_view) begin
          if (setting_mode == MODE_IDLE) begin
            time_hour_next   = held.clock_hour;
            time_minute_next = held.clock_minute;
            time_second_next = held.clock_second;
            if (held.clock_hour == alarm_hour && held.clock_minute == alarm_minute &&
                held.clock_second == alarm_second) begin
              blinks_left_next = ALARM_STEPS;
            end
          end
          if (second_parity) begin
            case (setting_mode)
              MODE_CLK_HOUR, MODE_ALM_HOUR: blank = BLANK_HOUR;
              MODE_CLK_MIN, MODE_ALM_MIN:   blank = BLANK_MINUTE;
              MODE_CLK_SEC, MODE_ALM_SEC:   blank = BLANK_SECOND;
              default:                      blank = BLANK_NONE;
            endcase
          end
        end
      end

      OP_TICK: begin
        millisecond_count_next = (ms_inc >= 10'(MS_PER_SECOND)) ? 10'd0 : ms_inc;
        if (blinks_left != 5'd0 && blink_step(millisecond_count_next)) begin
          blinks_left_next = blinks_dec;
          led_level_next   = (blinks_dec != 5'd0) ? !led_level : 1'b0;
        end
        if (millisecond_count_next == 10'd0) begin
          second_parity_next = !second_parity;
        end
      end

      default: ;
    endcase
  end

  assign alarm_view = (setting_mode_next >= MODE_ALM_HOUR);

  always_comb begin
    res.mode             = setting_mode_next;
    res.shown_hour       = alarm_view ? alarm_hour_next : time_hour_next;
    res.shown_minute     = alarm_view ? alarm_minute_next : time_minute_next;
    res.shown_second     = alarm_view ? alarm_second_next : time_second_next;
    res.blanked_pair     = blank;
    res.show_temperature = temperature_view_next;
    res.alarm_led        = led_level_next;
    res.write_clock      = write_clock;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      setting_mode      <= MODE_IDLE;
      time_hour         <= RESET_HOUR;
      time_minute       <= RESET_MINUTE;
      time_second       <= RESET_SECOND;
      alarm_hour        <= 5'd0;
      alarm_minute      <= 6'd0;
      alarm_second      <= 6'd0;
      previous_key      <= KEY_NONE;
      temperature_view  <= 1'b0;
      blinks_left       <= 5'd0;
      led_level         <= 1'b0;
      millisecond_count <= 10'd0;
      second_parity     <= 1'b0;
    end else if (fire) begin
      setting_mode      <= setting_mode_next;
      time_hour         <= time_hour_next;
      time_minute       <= time_minute_next;
      time_second       <= time_second_next;
      alarm_hour        <= alarm_hour_next;
      alarm_minute      <= alarm_minute_next;
      alarm_second      <= alarm_second_next;
      previous_key      <= previous_key_next;
      temperature_view  <= temperature_view_next;
      blinks_left       <= blinks_left_next;
      led_level         <= led_level_next;
      millisecond_count <= millisecond_count_next;
      second_parity     <= second_parity_next;
    end
  end

  a_led_needs_blinks: assert property (@(posedge clk) disable iff (rst)
    led_level |-> blinks_left != 5'd0)
    else $error("alarm LED lit with no blinks left");

  a_blinks_bounded: assert property (@(posedge clk) disable iff (rst)
    blinks_left <= ALARM_STEPS)
    else $error("blink count beyond alarm length");

  a_ms_bounded: assert property (@(posedge clk) disable iff (rst)
    millisecond_count < 10'(MS_PER_SECOND))
    else $error("millisecond count out of range");

  a_write_leaves_to_idle: assert property (@(posedge clk) disable iff (rst)
    fire && res.write_clock |=> setting_mode == MODE_IDLE && $past(setting_mode) == MODE_CLK_SEC)
    else $error("clock write outside the exit from second setting");

  a_blank_only_setting: assert property (@(posedge clk) disable iff (rst)
    fire && res.blanked_pair != BLANK_NONE |-> setting_mode != MODE_IDLE && second_parity)
    else $error("digits blanked outside a setting mode");

endmodule

`default_nettype wire

>>> design/acs_out_stage.sv
// Result register: holds one result until the sink takes it.
`default_nettype none

module acs_out_stage
  import acs_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    load,
  input  wire result_t res,
  output logic         space,
  acs_out_if.source    result
);

  result_t data;

  assign space = !result.valid || result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (load) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data <= res;
    end
  end

  assign result.mode             = data.mode;
  assign result.shown_hour       = data.shown_hour;
  assign result.shown_minute     = data.shown_minute;
  assign result.shown_second     = data.shown_second;
  assign result.blanked_pair     = data.blanked_pair;
  assign result.show_temperature = data.show_temperature;
  assign result.alarm_led        = data.alarm_led;
  assign result.write_clock      = data.write_clock;

endmodule

`default_nettype wire
